### rtl/core/wcup_pkg.sv
package wcup_pkg;

    // size limits of the record and of each value
    localparam int RECORD_LIMIT   = 255;
    localparam int SSID_LIMIT     = 63;
    localparam int TYPE_LIMIT     = 31;
    localparam int PASSWORD_LIMIT = 63;

    // first ';' of the closing pair must lie beyond this offset
    localparam int END_MIN_OFFSET = 10;

    // entries in the result queue
    localparam int RESULT_QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_W     = 8'h57;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_P     = 8'h50;

    localparam logic [2:0] PREFIX_LEN  = 3'd5;
    localparam logic [2:0] NONE_LEN    = 3'd4;
    localparam logic [2:0] NONE_BROKEN = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_SSID    = 2'd0;
    localparam logic [1:0] KIND_TYPE    = 2'd1;
    localparam logic [1:0] KIND_PASS    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       first;
        logic       found;
        logic [5:0] ssid_len;
        logic [4:0] type_len;
        logic [5:0] pass_len;
        logic       is_none;
        logic       none_pw;
        logic       trunc;
        logic       last;
    } t_result;

    // up to two results produced by one accepted byte, value result first
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    // "WIFI:"
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h57;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h46;
            3'd3:    c = 8'h49;
            3'd4:    c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "NONE"
    function automatic logic [7:0] none_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h4E;
            2'd1:    c = 8'h4F;
            2'd2:    c = 8'h4E;
            2'd3:    c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/wcup_step.sv
module wcup_step
    import wcup_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eob,
    output t_push      o_push
);

    typedef enum logic [1:0] {PH_SEARCH, PH_RECORD, PH_DONE} t_phase;
    typedef enum logic [1:0] {MODE_IDLE, MODE_SSID, MODE_TYPE, MODE_PASS} t_mode;

    t_phase     r_phase,       n_phase;
    logic [2:0] r_prefix,      n_prefix;
    logic [7:0] r_offset,      n_offset;
    t_mode      r_mode,        n_mode;
    t_mode      r_pending,     n_pending;
    logic       r_prior_semi,  n_prior_semi;
    logic [5:0] r_ssid_cnt,    n_ssid_cnt;
    logic [4:0] r_type_cnt,    n_type_cnt;
    logic [5:0] r_pass_cnt,    n_pass_cnt;
    logic [2:0] r_none_prog,   n_none_prog;
    logic       r_overflow,    n_overflow;

    logic       store_full;
    logic       is_none;

    always_comb begin
        n_phase      = r_phase;
        n_prefix     = r_prefix;
        n_offset     = r_offset;
        n_mode       = r_mode;
        n_pending    = r_pending;
        n_prior_semi = r_prior_semi;
        n_ssid_cnt   = r_ssid_cnt;
        n_type_cnt   = r_type_cnt;
        n_pass_cnt   = r_pass_cnt;
        n_none_prog  = r_none_prog;
        n_overflow   = r_overflow;
        store_full   = 1'b0;
        is_none      = 1'b0;
        o_push       = '0;

        case (r_phase)
            PH_SEARCH: begin
                if (r_prefix < PREFIX_LEN && i_byte == prefix_char(r_prefix)) begin
                    n_prefix = r_prefix + 3'd1;
                end else begin
                    n_prefix = (i_byte == CHAR_W) ? 3'd1 : 3'd0;
                end
                if (n_prefix >= PREFIX_LEN) begin
                    n_prefix = 3'd0;
                    if (!i_eob) begin
                        n_phase  = PH_RECORD;
                        n_offset = 8'(PREFIX_LEN);
                    end
                end
            end
            PH_RECORD: begin
                if (r_prior_semi && i_byte == CHAR_SEMI) begin
                    n_phase = PH_DONE;
                end else if (r_offset >= 8'(RECORD_LIMIT)) begin
                    n_overflow = 1'b1;
                    n_phase    = PH_DONE;
                end else begin
                    n_offset     = r_offset + 8'd1;
                    n_prior_semi = (i_byte == CHAR_SEMI) && (r_offset > 8'(END_MIN_OFFSET))
                                   && !i_eob;
                    if (i_byte == 8'h00) begin
                        // a zero byte ends parsing like a string end
                        n_phase   = PH_DONE;
                        n_mode    = MODE_IDLE;
                        n_pending = MODE_IDLE;
                    end else if (r_mode != MODE_IDLE) begin
                        if (i_byte == CHAR_SEMI) begin
                            n_mode = MODE_IDLE;
                        end else begin
                            o_push.r0.value = i_byte;
                            case (r_mode)
                                MODE_SSID: begin
                                    store_full        = r_ssid_cnt >= 6'(SSID_LIMIT);
                                    o_push.r0.kind    = KIND_SSID;
                                    o_push.r0.first   = (r_ssid_cnt == 6'd0);
                                    if (!store_full) n_ssid_cnt = r_ssid_cnt + 6'd1;
                                end
                                MODE_TYPE: begin
                                    store_full        = r_type_cnt >= 5'(TYPE_LIMIT);
                                    o_push.r0.kind    = KIND_TYPE;
                                    o_push.r0.first   = (r_type_cnt == 5'd0);
                                    if (!store_full) begin
                                        n_type_cnt = r_type_cnt + 5'd1;
                                        if (r_none_prog < NONE_LEN
                                            && i_byte == none_char(r_none_prog[1:0])) begin
                                            n_none_prog = r_none_prog + 3'd1;
                                        end else begin
                                            n_none_prog = NONE_BROKEN;
                                        end
                                    end
                                end
                                default: begin
                                    store_full        = r_pass_cnt >= 6'(PASSWORD_LIMIT);
                                    o_push.r0.kind    = KIND_PASS;
                                    o_push.r0.first   = (r_pass_cnt == 6'd0);
                                    if (!store_full) n_pass_cnt = r_pass_cnt + 6'd1;
                                end
                            endcase
                            if (store_full) begin
                                n_overflow = 1'b1;
                            end else begin
                                o_push.v0      = 1'b1;
                                o_push.r0.last = !i_eob;
                            end
                        end
                    end else begin
                        n_pending = MODE_IDLE;
                        if (r_pending != MODE_IDLE && i_byte == CHAR_COLON) begin
                            n_mode = r_pending;
                            case (r_pending)
                                MODE_SSID: n_ssid_cnt = 6'd0;
                                MODE_TYPE: begin
                                    n_type_cnt  = 5'd0;
                                    n_none_prog = 3'd0;
                                end
                                default:   n_pass_cnt = 6'd0;
                            endcase
                        end else if (i_byte == CHAR_S) begin
                            n_pending = MODE_SSID;
                        end else if (i_byte == CHAR_T) begin
                            n_pending = MODE_TYPE;
                        end else if (i_byte == CHAR_P) begin
                            n_pending = MODE_PASS;
                        end
                    end
                end
            end
            default: begin
                // record closed, wait for the buffer end
            end
        endcase

        if (i_eob) begin
            is_none = (n_none_prog == NONE_LEN) && (n_type_cnt == 5'(NONE_LEN));
            o_push.v1          = 1'b1;
            o_push.r1.kind     = KIND_SUMMARY;
            o_push.r1.found    = (n_phase != PH_SEARCH);
            o_push.r1.ssid_len = n_ssid_cnt;
            o_push.r1.type_len = n_type_cnt;
            o_push.r1.pass_len = n_pass_cnt;
            o_push.r1.is_none  = is_none;
            o_push.r1.none_pw  = is_none && (n_pass_cnt != 6'd0);
            o_push.r1.trunc    = n_overflow;
            o_push.r1.last     = 1'b1;
            // back to reset state for the next buffer
            n_phase      = PH_SEARCH;
            n_prefix     = 3'd0;
            n_offset     = 8'd0;
            n_mode       = MODE_IDLE;
            n_pending    = MODE_IDLE;
            n_prior_semi = 1'b0;
            n_ssid_cnt   = 6'd0;
            n_type_cnt   = 5'd0;
            n_pass_cnt   = 6'd0;
            n_none_prog  = 3'd0;
            n_overflow   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEARCH;
            r_prefix     <= 3'd0;
            r_offset     <= 8'd0;
            r_mode       <= MODE_IDLE;
            r_pending    <= MODE_IDLE;
            r_prior_semi <= 1'b0;
            r_ssid_cnt   <= 6'd0;
            r_type_cnt   <= 5'd0;
            r_pass_cnt   <= 6'd0;
            r_none_prog  <= 3'd0;
            r_overflow   <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_prefix     <= n_prefix;
            r_offset     <= n_offset;
            r_mode       <= n_mode;
            r_pending    <= n_pending;
            r_prior_semi <= n_prior_semi;
            r_ssid_cnt   <= n_ssid_cnt;
            r_type_cnt   <= n_type_cnt;
            r_pass_cnt   <= n_pass_cnt;
            r_none_prog  <= n_none_prog;
            r_overflow   <= n_overflow;
        end
    end

    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix < PREFIX_LEN)
        else $error("prefix progress out of range");

    a_eob_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eob) |=> (r_phase == PH_SEARCH && r_offset == 8'd0 && !r_overflow))
        else $error("state not cleared after buffer end");

    a_search_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEARCH) |-> (r_mode == MODE_IDLE && r_ssid_cnt == 6'd0))
        else $error("parse state active while searching");

endmodule

### rtl/core/wcup_out_fifo.sv
module wcup_out_fifo
    import wcup_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_en,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room2,
    output logic    o_valid,
    output t_result o_head
);

    t_result    r_mem [RESULT_QUEUE_DEPTH];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr;
    logic [2:0] r_count, n_count;
    logic [1:0] wr_second;
    logic [1:0] n_push;
    logic       pop_en;

    assign o_valid   = (r_count != 3'd0);
    assign o_head    = r_mem[r_rptr];
    assign o_room2   = (r_count <= 3'(RESULT_QUEUE_DEPTH - 2));
    assign pop_en    = i_pop && o_valid;
    assign n_push    = i_push_en ? (2'(i_push.v0) + 2'(i_push.v1)) : 2'd0;
    assign wr_second = r_wptr + 2'(i_push.v0);
    assign n_wptr    = r_wptr + n_push;
    assign n_count   = r_count + 3'(n_push) - 3'(pop_en);

    always_ff @(posedge i_clk) begin
        if (i_push_en && i_push.v0) r_mem[r_wptr] <= i_push.r0;
        if (i_push_en && i_push.v1) r_mem[wr_second] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (pop_en) r_rptr <= r_rptr + 2'd1;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(RESULT_QUEUE_DEPTH))
        else $error("result queue overrun");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_en |-> o_room2)
        else $error("push without room for two results");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[1:0])
        else $error("queue pointers disagree with count");

endmodule

### rtl/core/wifi_config_uri_parser_core.sv
// wifi network configuration uri parser
// s_axis: one payload byte per request, tdata[7:0] the byte, tlast marks the final
//   byte of the buffer; the parser finds the WIFI: prefix and walks the S:, T: and
//   P: fields of the record
// m_axis: results; tuser is the kind (ssid, auth type, password, summary), tlast the
//   last result caused by one input byte; value bytes carry field_first, and one
//   summary with lengths and flags follows each buffer end
// results are registered in the result queue and offered from its head
// throughput: one byte per cycle; a byte yields at most two results (value then
//   summary), held in a four-entry result queue that drains one per cycle
// s_axis_tready is high while the queue has room for two results, so a stalled
//   receiver fills the queue and then holds off the sender; nothing is lost
// reset: synchronous, active low; clears the parser state and empties the queue,
//   and each buffer end returns the parser to that same state
module wifi_config_uri_parser_core
    import wcup_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] value_byte, [8] field_first, [9] prefix_seen, [15:10] ssid_length,
    // [20:16] type_length, [26:21] password_length, [27] type_is_none,
    // [28] none_with_password, [29] truncated, [31:30] zero
    output logic [31:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast    // last_result
);

    logic    in_accept;
    t_push   step_push;
    t_result head;

    // accept only while the queue can take a full value-plus-summary pair
    assign in_accept = s_axis_tvalid && s_axis_tready;

    wcup_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_eob    (s_axis_tlast),
        .o_push   (step_push)
    );

    wcup_out_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (in_accept),
        .i_push    (step_push),
        .i_pop     (m_axis_tready),
        .o_room2   (s_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_head    (head)
    );

    // result fields packed from bit 0 upwards
    assign m_axis_tdata = {2'b00, head.trunc, head.none_pw, head.is_none, head.pass_len,
                           head.type_len, head.ssid_len, head.found, head.first,
                           head.value};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
